// File: rtl/bcqi_pkg.sv
// Shared types, constants and helpers of the conserved-quantity integrator.
// Holds the micro-op sequence of the shared multiplier and the saturating add.
// No dependencies.
`default_nettype none

package bcqi_pkg;

  localparam int NQ      = 8;
  localparam int N_STEPS = 20;
  localparam int OPD_W   = 33;
  localparam int PROD_W  = 2 * OPD_W;
  localparam int ACC_W   = 128;
  localparam int CYC_W   = 5;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  // Running sum slots
  localparam logic [2:0] Q_MASS = 3'd0;
  localparam logic [2:0] Q_XMOM = 3'd1;
  localparam logic [2:0] Q_YMOM = 3'd2;
  localparam logic [2:0] Q_ZMOM = 3'd3;
  localparam logic [2:0] Q_ENER = 3'd4;
  localparam logic [2:0] Q_KIN  = 3'd5;
  localparam logic [2:0] Q_INT  = 3'd6;
  localparam logic [2:0] Q_MAG  = 3'd7;

  typedef enum logic [3:0] {
    OPD_DENS,
    OPD_VOL,
    OPD_VX,
    OPD_VY,
    OPD_VZ,
    OPD_ESP,
    OPD_EINT,
    OPD_MAGP,
    OPD_MLO,
    OPD_MHI,
    OPD_SLO,
    OPD_SHI
  } opnd_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_MASS,
    ACT_VSQ0,
    ACT_VSQ,
    ACT_MAG,
    ACT_SUM,
    ACT_EN,
    ACT_ENSUM
  } act_e;

  typedef struct packed {
    opnd_e      a;
    opnd_e      b;
    logic [1:0] off;    // partial product weight, in units of 32 bits
    logic       first;  // start a fresh accumulation
    logic       fin;    // accumulation complete, hand to the finish stage
    act_e       act;
    logic [2:0] q;      // running sum touched by the finish stage
    logic       half;   // one more bit of shift (the 1/2 of kinetic energy)
  } uop_t;

  function automatic uop_t mk(opnd_e a, opnd_e b, logic [1:0] off, logic first,
                              logic fin, act_e act, logic [2:0] q, logic half);
    uop_t u;
    u.a = a; u.b = b; u.off = off; u.first = first; u.fin = fin;
    u.act = act; u.q = q; u.half = half;
    return u;
  endfunction

  function automatic uop_t uop(logic [CYC_W-1:0] step);
    uop_t u;
    case (step)
      5'd0:    u = mk(OPD_DENS, OPD_VOL,  2'd0, 1'b1, 1'b1, ACT_MASS,  Q_MASS, 1'b0);
      5'd1:    u = mk(OPD_VX,   OPD_VX,   2'd0, 1'b1, 1'b1, ACT_VSQ0,  Q_MASS, 1'b0);
      5'd2:    u = mk(OPD_VY,   OPD_VY,   2'd0, 1'b1, 1'b1, ACT_VSQ,   Q_MASS, 1'b0);
      5'd3:    u = mk(OPD_VZ,   OPD_VZ,   2'd0, 1'b1, 1'b1, ACT_VSQ,   Q_MASS, 1'b0);
      5'd4:    u = mk(OPD_MAGP, OPD_VOL,  2'd0, 1'b1, 1'b1, ACT_MAG,   Q_MAG,  1'b0);
      5'd5:    u = mk(OPD_MLO,  OPD_VX,   2'd0, 1'b1, 1'b0, ACT_NONE,  Q_XMOM, 1'b0);
      5'd6:    u = mk(OPD_MHI,  OPD_VX,   2'd1, 1'b0, 1'b1, ACT_SUM,   Q_XMOM, 1'b0);
      5'd7:    u = mk(OPD_MLO,  OPD_VY,   2'd0, 1'b1, 1'b0, ACT_NONE,  Q_YMOM, 1'b0);
      5'd8:    u = mk(OPD_MHI,  OPD_VY,   2'd1, 1'b0, 1'b1, ACT_SUM,   Q_YMOM, 1'b0);
      5'd9:    u = mk(OPD_MLO,  OPD_VZ,   2'd0, 1'b1, 1'b0, ACT_NONE,  Q_ZMOM, 1'b0);
      5'd10:   u = mk(OPD_MHI,  OPD_VZ,   2'd1, 1'b0, 1'b1, ACT_SUM,   Q_ZMOM, 1'b0);
      5'd11:   u = mk(OPD_MLO,  OPD_ESP,  2'd0, 1'b1, 1'b0, ACT_NONE,  Q_ENER, 1'b0);
      5'd12:   u = mk(OPD_MHI,  OPD_ESP,  2'd1, 1'b0, 1'b1, ACT_EN,    Q_ENER, 1'b0);
      5'd13:   u = mk(OPD_MLO,  OPD_EINT, 2'd0, 1'b1, 1'b0, ACT_NONE,  Q_INT,  1'b0);
      5'd14:   u = mk(OPD_MHI,  OPD_EINT, 2'd1, 1'b0, 1'b1, ACT_SUM,   Q_INT,  1'b0);
      5'd15:   u = mk(OPD_MLO,  OPD_SLO,  2'd0, 1'b1, 1'b0, ACT_NONE,  Q_KIN,  1'b1);
      5'd16:   u = mk(OPD_MLO,  OPD_SHI,  2'd1, 1'b0, 1'b0, ACT_NONE,  Q_KIN,  1'b1);
      5'd17:   u = mk(OPD_MHI,  OPD_SLO,  2'd1, 1'b0, 1'b0, ACT_NONE,  Q_KIN,  1'b1);
      5'd18:   u = mk(OPD_MHI,  OPD_SHI,  2'd2, 1'b0, 1'b1, ACT_SUM,   Q_KIN,  1'b1);
      // no product: fold the finished cell energy into its running sum
      5'd19:   u = mk(OPD_DENS, OPD_VOL,  2'd0, 1'b1, 1'b1, ACT_ENSUM, Q_ENER, 1'b0);
      default: u = mk(OPD_DENS, OPD_VOL,  2'd0, 1'b1, 1'b0, ACT_NONE,  Q_MASS, 1'b0);
    endcase
    return u;
  endfunction

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      return a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/block_conserved_quantity_integrator.sv
// Conserved-quantity integrator: per-cell sums and per-slot totals store.
// One shared 33x33 multiplier with accumulator under a step sequencer.
// Depends on bcqi_pkg.
//
// Usage: the input channel (in_valid_i / in_stall_o) takes one cell word per
// item; the output channel (out_valid_o / out_stall_i) gives one totals word
// for each cell word that carries last_cell. A cell is worked through
// before the next is taken: 20 sequencer steps (mass, three squared speeds,
// magnetic term, two or four partial products per mass-weighted quantity,
// then the energy fold), a two-stage accumulate/finish drain, and a return
// to idle, which takes the next word. A last cell then passes a hand-off
// state and a read-modify-write pass over the eight totals of its slot
// through the store's one read and one write port before its result shows.
// A result waits in the output register while the receiver stalls; the next
// cell is still taken and worked, and only a following last cell holds until
// the output register is free.
// After reset the totals store is cleared one entry a cycle, all BLOCK_SLOTS*8
// entries (2048 at the default); in_stall_o stays high until that is done.
// The running sums reset to zero.
`default_nettype none

module block_conserved_quantity_integrator
  import bcqi_pkg::*;
#(
  parameter int BLOCK_SLOTS = 256,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [7:0]         block_index_i,
  input  wire logic [30:0]        density_i,
  input  wire logic signed [31:0] vel_x_i,
  input  wire logic signed [31:0] vel_y_i,
  input  wire logic signed [31:0] vel_z_i,
  input  wire logic signed [31:0] specific_energy_i,
  input  wire logic signed [31:0] specific_internal_i,
  input  wire logic signed [31:0] magnetic_pressure_i,
  input  wire logic [30:0]        cell_volume_i,
  input  wire logic               last_cell_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [7:0]         slot_out_o,
  output      logic signed [63:0] mass_total_o,
  output      logic signed [63:0] xmom_total_o,
  output      logic signed [63:0] ymom_total_o,
  output      logic signed [63:0] zmom_total_o,
  output      logic signed [63:0] energy_total_o,
  output      logic signed [63:0] kinetic_total_o,
  output      logic signed [63:0] internal_total_o,
  output      logic signed [63:0] magnetic_total_o
);

  localparam int SLOT_W    = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
  localparam int ADDR_W    = SLOT_W + 3;
  localparam int MEM_DEPTH = BLOCK_SLOTS * NQ;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_TWAIT = 3'd3;
  localparam logic [2:0] S_TOT   = 3'd4;

  localparam logic [CYC_W-1:0] CYC_END = CYC_W'(N_STEPS + 1);
  localparam logic [3:0]       TQ_END  = 4'(NQ);

  // slot reduction table, one entry per possible block_index
  logic [7:0] slot_tab [256];
  for (genvar g = 0; g < 256; g++) begin : g_slot
    assign slot_tab[g] = 8'(g % BLOCK_SLOTS);
  end

  logic [2:0]       state_q;
  logic [CYC_W-1:0] cyc_q;
  logic [3:0]       tq_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic             last_q;
  logic [7:0]       slot_q;

  // captured cell word
  logic [30:0]        dens_q, vol_q;
  logic signed [31:0] vx_q, vy_q, vz_q, esp_q, eint_q, magp_q;

  // intermediate values
  logic signed [63:0] mass_q, vsq_q, mag_q, en_q;
  logic signed [63:0] rs_q [NQ];

  // multiply / accumulate / finish pipeline
  uop_t                      cur_uop;
  logic signed [OPD_W-1:0]   opa, opb;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  uop_t                      t1_q, t2_q;
  logic                      v1_q, v2_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d, prod_ext, prod_sh, acc_sh;
  logic signed [63:0]        val;

  // shared saturating adder
  logic signed [63:0] sa_a, sa_b, sa_y;

  // totals store
  logic signed [63:0] mem [MEM_DEPTH];
  logic signed [63:0] mem_rd_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic signed [63:0] mem_wdata;
  logic [2:0]         upd_idx;

  logic               out_valid_q;
  logic [7:0]         slot_out_q;
  logic signed [63:0] tot_q [NQ];

  logic in_acc;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign upd_idx    = 3'(tq_q - 4'd1);

  function automatic logic signed [OPD_W-1:0] opnd_sel(
    opnd_e c, logic [30:0] dens, logic [30:0] vol, logic signed [31:0] vx,
    logic signed [31:0] vy, logic signed [31:0] vz, logic signed [31:0] esp,
    logic signed [31:0] eint, logic signed [31:0] magp,
    logic signed [63:0] mass, logic signed [63:0] vsq);
    logic signed [OPD_W-1:0] r;
    case (c)
      OPD_DENS: r = {2'b00, dens};
      OPD_VOL:  r = {2'b00, vol};
      OPD_VX:   r = {vx[31], vx};
      OPD_VY:   r = {vy[31], vy};
      OPD_VZ:   r = {vz[31], vz};
      OPD_ESP:  r = {esp[31], esp};
      OPD_EINT: r = {eint[31], eint};
      OPD_MAGP: r = {magp[31], magp};
      OPD_MLO:  r = {1'b0, mass[31:0]};
      OPD_MHI:  r = {mass[63], mass[63:32]};
      OPD_SLO:  r = {1'b0, vsq[31:0]};
      OPD_SHI:  r = {vsq[63], vsq[63:32]};
      default:  r = '0;
    endcase
    return r;
  endfunction

  assign cur_uop = uop(cyc_q);
  assign opa = opnd_sel(cur_uop.a, dens_q, vol_q, vx_q, vy_q, vz_q, esp_q, eint_q,
                        magp_q, mass_q, vsq_q);
  assign opb = opnd_sel(cur_uop.b, dens_q, vol_q, vx_q, vy_q, vz_q, esp_q, eint_q,
                        magp_q, mass_q, vsq_q);
  assign prod_d = opa * opb;

  // accumulate stage
  always_comb begin
    prod_ext = ACC_W'(prod_q);
    case (t1_q.off)
      2'd1:    prod_sh = prod_ext <<< 32;
      2'd2:    prod_sh = prod_ext <<< 64;
      default: prod_sh = prod_ext;
    endcase
    acc_d = (t1_q.first ? '0 : acc_q) + prod_sh;
  end

  // finish stage: rescale, saturate, and pick the adder operands
  always_comb begin
    acc_sh = t2_q.half ? (acc_q >>> (FRAC_BITS + 1)) : (acc_q >>> FRAC_BITS);
    if ((&acc_sh[ACC_W-1:63]) || !(|acc_sh[ACC_W-1:63])) begin
      val = acc_sh[63:0];
    end else begin
      val = acc_sh[ACC_W-1] ? S64_MIN : S64_MAX;
    end
    sa_a = rs_q[t2_q.q];
    sa_b = val;
    if (state_q == S_TOT) begin
      sa_a = mem_rd_q;
      sa_b = rs_q[upd_idx];
    end else begin
      case (t2_q.act)
        ACT_VSQ0:  sa_a = '0;
        ACT_VSQ:   sa_a = vsq_q;
        ACT_EN:    sa_a = mag_q;
        ACT_ENSUM: sa_b = en_q;
        default:   sa_a = rs_q[t2_q.q];
      endcase
    end
    sa_y = sat_add(sa_a, sa_b);
  end

  // store port selection
  always_comb begin
    mem_raddr = {SLOT_W'(slot_q), tq_q[2:0]};
    if (state_q == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = (state_q == S_TOT) && (tq_q != 4'd0);
      mem_waddr = {SLOT_W'(slot_q), upd_idx};
      mem_wdata = sa_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_q <= mem[mem_raddr];
  end

  // control and running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cyc_q       <= '0;
      tq_q        <= '0;
      clr_addr_q  <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NQ; i++) begin
        rs_q[i] <= '0;
      end
    end else begin
      v1_q <= (state_q == S_RUN) && (cyc_q < CYC_W'(N_STEPS));
      v2_q <= v1_q && t1_q.fin;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (v2_q) begin
        case (t2_q.act)
          ACT_MASS, ACT_MAG, ACT_SUM, ACT_ENSUM: rs_q[t2_q.q] <= sa_y;
          default: ;
        endcase
      end
      case (state_q)
        S_CLR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_RUN;
            cyc_q   <= '0;
          end
        end
        S_RUN: begin
          cyc_q <= cyc_q + 1'b1;
          if (cyc_q == CYC_END) begin
            state_q <= last_q ? S_TWAIT : S_IDLE;
          end
        end
        S_TWAIT: begin
          // hold until the previous result has been taken
          if (!out_valid_q) begin
            state_q <= S_TOT;
            tq_q    <= '0;
          end
        end
        S_TOT: begin
          tq_q <= tq_q + 1'b1;
          if (tq_q == TQ_END) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
            for (int i = 0; i < NQ; i++) begin
              rs_q[i] <= '0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dens_q <= density_i;
      vol_q  <= cell_volume_i;
      vx_q   <= vel_x_i;
      vy_q   <= vel_y_i;
      vz_q   <= vel_z_i;
      esp_q  <= specific_energy_i;
      eint_q <= specific_internal_i;
      magp_q <= magnetic_pressure_i;
      last_q <= last_cell_i;
      slot_q <= slot_tab[block_index_i];
    end
    prod_q <= prod_d;
    t1_q   <= cur_uop;
    t2_q   <= t1_q;
    if (v1_q) begin
      acc_q <= acc_d;
    end
    if (v2_q) begin
      case (t2_q.act)
        ACT_MASS:          mass_q <= val;
        ACT_MAG:           mag_q  <= val;
        ACT_VSQ0, ACT_VSQ: vsq_q  <= sa_y;
        ACT_EN:            en_q   <= sa_y;
        default: ;
      endcase
    end
    if (state_q == S_TOT && tq_q != 4'd0) begin
      tot_q[upd_idx] <= sa_y;
    end
    if (state_q == S_TOT && tq_q == TQ_END) begin
      slot_out_q <= slot_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign slot_out_o       = slot_out_q;
  assign mass_total_o     = tot_q[Q_MASS];
  assign xmom_total_o     = tot_q[Q_XMOM];
  assign ymom_total_o     = tot_q[Q_YMOM];
  assign zmom_total_o     = tot_q[Q_ZMOM];
  assign energy_total_o   = tot_q[Q_ENER];
  assign kinetic_total_o  = tot_q[Q_KIN];
  assign internal_total_o = tot_q[Q_INT];
  assign magnetic_total_o = tot_q[Q_MAG];

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_RUN) && (cyc_q == '0))
    else $error("accepted word did not start the sequencer");

  a_result_from_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_TOT))
    else $error("result raised outside the totals pass");

  a_sums_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TOT && tq_q == TQ_END) |=>
      (rs_q[Q_MASS] == '0) && (rs_q[Q_KIN] == '0) && (rs_q[Q_MAG] == '0))
    else $error("running sums not cleared after totals pass");

  a_finish_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (state_q == S_RUN))
    else $error("finish stage active outside the cell sequence");

  a_totals_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TOT) |-> !out_valid_q)
    else $error("totals pass overwrote a pending result");

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for block_conserved_quantity_integrator: directed and random
// cell words with random idle and stall on both channels, checked against a fixed-point
// integrator model. Depends on bcqi_pkg and the integrator RTL.

module tb;
  import bcqi_pkg::*;

  localparam int FRAC        = 16;
  localparam int RANDOM_CELLS = 1200;
  localparam int QUIET_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 80;
  localparam int PRINT_CAP    = 40;

  typedef struct {
    logic [7:0]  slot;
    logic [30:0] density;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [31:0] spec_energy;
    logic [31:0] spec_internal;
    logic [31:0] mag_pressure;
    logic [30:0] volume;
    logic        last;
    logic        hold;   // hold off until every pending totals word is out
  } cell_t;

  typedef struct packed {
    logic [7:0]          slot;
    logic [NQ-1:0][63:0] tot;
  } totals_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] block_index_i = '0;
  logic [30:0] density_i = '0;
  logic signed [31:0] vel_x_i = '0;
  logic signed [31:0] vel_y_i = '0;
  logic signed [31:0] vel_z_i = '0;
  logic signed [31:0] specific_energy_i = '0;
  logic signed [31:0] specific_internal_i = '0;
  logic signed [31:0] magnetic_pressure_i = '0;
  logic [30:0] cell_volume_i = '0;
  logic last_cell_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [7:0] slot_out_o;
  logic signed [63:0] mass_total_o;
  logic signed [63:0] xmom_total_o;
  logic signed [63:0] ymom_total_o;
  logic signed [63:0] zmom_total_o;
  logic signed [63:0] energy_total_o;
  logic signed [63:0] kinetic_total_o;
  logic signed [63:0] internal_total_o;
  logic signed [63:0] magnetic_total_o;

  block_conserved_quantity_integrator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cell_t       pending_cells[$];
  totals_t     totals_due[$];
  cell_t       cur_cell;
  totals_t     want;
  logic [NQ-1:0][63:0] seen_tot;
  logic signed [63:0]  run_sum[NQ];
  logic signed [63:0]  slot_totals[256][NQ];
  logic        sending = 1'b0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned recv_stall = 3;
  int unsigned recv_calm = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_errors = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    // keep the log short, keep counting
    if (n_errors < PRINT_CAP)
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, exp_val);
    n_errors++;
  endtask

  function automatic string qty_name(int q);
    case (q)
      Q_MASS:  return "mass_total";
      Q_XMOM:  return "xmom_total";
      Q_YMOM:  return "ymom_total";
      Q_ZMOM:  return "zmom_total";
      Q_ENER:  return "energy_total";
      Q_KIN:   return "kinetic_total";
      Q_INT:   return "internal_total";
      default: return "magnetic_total";
    endcase
  endfunction

  // exact product, floor shift, clamp to 64 bits
  function automatic logic signed [63:0] scaled_product(logic signed [63:0] a,
                                                        logic signed [63:0] b,
                                                        int unsigned sh);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] wide;
    wa = a;
    wb = b;
    wide = (wa * wb) >>> sh;
    if (wide[127:63] == {65{wide[63]}}) return wide[63:0];
    return wide[127] ? S64_MIN : S64_MAX;
  endfunction

  function automatic logic signed [63:0] clamp_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic void integrate_cell(cell_t c);
    logic signed [63:0] dens, vol, vx, vy, vz, esp, eint, magp;
    logic signed [63:0] mass, vsq, magcell;
    logic signed [63:0] contrib[NQ];
    totals_t due;
    dens = {33'b0, c.density};
    vol  = {33'b0, c.volume};
    vx   = {{32{c.vel_x[31]}}, c.vel_x};
    vy   = {{32{c.vel_y[31]}}, c.vel_y};
    vz   = {{32{c.vel_z[31]}}, c.vel_z};
    esp  = {{32{c.spec_energy[31]}}, c.spec_energy};
    eint = {{32{c.spec_internal[31]}}, c.spec_internal};
    magp = {{32{c.mag_pressure[31]}}, c.mag_pressure};
    mass = scaled_product(dens, vol, FRAC);
    // squared speed stays well inside 64 bits, plain add
    vsq = scaled_product(vx, vx, FRAC) + scaled_product(vy, vy, FRAC)
        + scaled_product(vz, vz, FRAC);
    magcell = scaled_product(magp, vol, FRAC);
    contrib[Q_MASS] = mass;
    contrib[Q_XMOM] = scaled_product(mass, vx, FRAC);
    contrib[Q_YMOM] = scaled_product(mass, vy, FRAC);
    contrib[Q_ZMOM] = scaled_product(mass, vz, FRAC);
    contrib[Q_ENER] = clamp_add(scaled_product(mass, esp, FRAC), magcell);
    contrib[Q_KIN]  = scaled_product(mass, vsq, FRAC + 1);
    contrib[Q_INT]  = scaled_product(mass, eint, FRAC);
    contrib[Q_MAG]  = magcell;
    for (int q = 0; q < NQ; q++) run_sum[q] = clamp_add(run_sum[q], contrib[q]);
    if (c.last) begin
      // 256 slots cover the whole index range, so no wrap is needed
      due.slot = c.slot;
      for (int q = 0; q < NQ; q++) begin
        slot_totals[c.slot][q] = clamp_add(slot_totals[c.slot][q], run_sum[q]);
        due.tot[q] = slot_totals[c.slot][q];
        run_sum[q] = '0;
      end
      totals_due.push_back(due);
    end
  endfunction

  function automatic int unsigned draw_idle(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [31:0] rand_word(bit is_unsigned);
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: begin
        case ($urandom_range(0, 3))
          0:       w = 32'h7FFF_FFFF;
          1:       w = 32'h8000_0000;
          2:       w = 32'hFFFF_FFFF;
          default: w = 32'h0000_0001;
        endcase
      end
      2, 3: w = $urandom;
      default: begin
        // up to 16.0, the range where sums stay unsaturated
        w = $urandom_range(0, 32'h0010_0000);
        if (!is_unsigned && $urandom_range(0, 1) == 1) w = -w;
      end
    endcase
    return w;
  endfunction

  task automatic push_cell(input logic [7:0] slot, input logic [30:0] dens,
                           input logic [31:0] vx, input logic [31:0] vy,
                           input logic [31:0] vz, input logic [31:0] esp,
                           input logic [31:0] eint, input logic [31:0] magp,
                           input logic [30:0] vol, input logic last);
    cell_t c;
    c.slot = slot;
    c.density = dens;
    c.vel_x = vx;
    c.vel_y = vy;
    c.vel_z = vz;
    c.spec_energy = esp;
    c.spec_internal = eint;
    c.mag_pressure = magp;
    c.volume = vol;
    c.last = last;
    c.hold = 1'b0;
    pending_cells.push_back(c);
  endtask

  // sender: one word in flight, idle drawn after each accept
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        integrate_cell(cur_cell);
        sending = 1'b0;
        send_gap = draw_idle(send_calm);
      end
      if (!sending) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_cells.size() > 0 &&
                     !(pending_cells[0].hold && totals_due.size() != 0)) begin
          cur_cell = pending_cells.pop_front();
          sending = 1'b1;
          block_index_i <= cur_cell.slot;
          density_i <= cur_cell.density;
          vel_x_i <= cur_cell.vel_x;
          vel_y_i <= cur_cell.vel_y;
          vel_z_i <= cur_cell.vel_z;
          specific_energy_i <= cur_cell.spec_energy;
          specific_internal_i <= cur_cell.spec_internal;
          magnetic_pressure_i <= cur_cell.mag_pressure;
          cell_volume_i <= cur_cell.volume;
          last_cell_i <= cur_cell.last;
        end
      end
      in_valid_i <= sending;
    end
  end

  // receiver: stall counts down only while a totals word is offered
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (totals_due.size() == 0) begin
          report_mismatch("totals word with nothing due", {56'b0, slot_out_o}, '0);
        end else begin
          want = totals_due.pop_front();
          if (slot_out_o !== want.slot)
            report_mismatch("slot_out", {56'b0, slot_out_o}, {56'b0, want.slot});
          seen_tot[Q_MASS] = mass_total_o;
          seen_tot[Q_XMOM] = xmom_total_o;
          seen_tot[Q_YMOM] = ymom_total_o;
          seen_tot[Q_ZMOM] = zmom_total_o;
          seen_tot[Q_ENER] = energy_total_o;
          seen_tot[Q_KIN]  = kinetic_total_o;
          seen_tot[Q_INT]  = internal_total_o;
          seen_tot[Q_MAG]  = magnetic_total_o;
          for (int q = 0; q < NQ; q++)
            if (seen_tot[q] !== want.tot[q])
              report_mismatch(qty_name(q), seen_tot[q], want.tot[q]);
        end
        recv_stall = draw_idle(recv_calm);
      end else if (out_valid_o && recv_stall > 0) begin
        recv_stall--;
      end
      out_stall_i <= (recv_stall > 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n_random;
    int unsigned len;
    logic [7:0]  slot;
    bit          hold_set;
    n_random = 0;
    hold_set = 1'b0;
    for (int q = 0; q < NQ; q++) begin
      run_sum[q] = '0;
      for (int s = 0; s < 256; s++) slot_totals[s][q] = '0;
    end

    // all zero, then unit values, then floor rounding of tiny negatives
    push_cell(8'd0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1);
    push_cell(8'd7, 31'h10000, 32'h10000, 32'hFFFF_0000, 32'h8000, 32'h20000,
              32'h10000, 32'h10000, 31'h10000, 1'b0);
    push_cell(8'd7, 31'h10000, 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
              32'h8000_0000, 32'hFFFF_FFFF, 31'h1, 1'b1);
    // largest cells: kinetic clamps per cell, energy clamps in the sum and totals
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < 4; i++)
        push_cell(8'd255, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, i == 3);
    // most negative fields: momenta and energies clamp low
    for (int i = 0; i < 5; i++)
      push_cell(8'd254, 31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, i == 4);
    push_cell(8'd254, 31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 1'b1);
    // zero density with large velocities, zero volume with large density
    push_cell(8'd128, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
    push_cell(8'd1, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, 1'b1);
    // pull a clamped-high slot back down
    push_cell(8'd255, 31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 1'b1);

    // random blocks of cells, each closed by a last cell
    while (n_random < RANDOM_CELLS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 8);
      slot = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      for (int i = 0; i < len; i++) begin
        push_cell(slot, 31'(rand_word(1'b1)), rand_word(1'b0), rand_word(1'b0),
                  rand_word(1'b0), rand_word(1'b0), rand_word(1'b0), rand_word(1'b0),
                  31'(rand_word(1'b1)), i == len - 1);
        // drain everything before the first random cell and once midway
        if (n_random == 0 || (!hold_set && n_random >= RANDOM_CELLS / 2)) begin
          pending_cells[pending_cells.size() - 1].hold = 1'b1;
          hold_set = (n_random != 0);
        end
        n_random++;
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_cells.size() != 0 || sending || totals_due.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
